@@ rtl/core/ocwm_pkg.sv @@
// Shared types, constants and the sine lookup for the omni chassis wheel mixer.
package ocwm_pkg;

    // Fixed-point setup of the mixer.
    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 12;
    localparam int TRIG_BITS  = 14;

    // Field and datapath widths.
    localparam int STICK_W  = 11;
    localparam int GAIN_W   = 16;
    localparam int YAW_W    = 16;
    localparam int WHEEL_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int VEL_W    = STICK_W + GAIN_W;          // scaled stick velocity
    localparam int TRIG_W   = TRIG_BITS + 2;             // signed Q1.14 sine/cosine
    localparam int PROD_W   = VEL_W + GAIN_W;            // velocity times trig or arm
    localparam int ROT_W    = VEL_W + 2;                 // rotated velocity
    localparam int DIFF_W   = ROT_W + 1;                 // sum or difference of two
    localparam int MIXK_W   = 15;
    localparam int KPROD_W  = DIFF_W + MIXK_W - 1;       // mix constant times velocity
    localparam int SPIN_W   = PROD_W + TRIG_BITS - FRAC_BITS;
    localparam int SUM_W    = ((SPIN_W > KPROD_W) ? SPIN_W : KPROD_W) + 2;
    localparam int MIX_SHIFT = TRIG_BITS + FRAC_BITS;
    localparam int RES_W    = SUM_W - MIX_SHIFT;

    // Heading mask keeps the top ANGLE_BITS bits of the turn fraction.
    localparam logic [YAW_W-1:0] ANGLE_MASK =
        YAW_W'(((64'd1 << ANGLE_BITS) - 64'd1) << (YAW_W - ANGLE_BITS));
    localparam logic [YAW_W-1:0] EIGHTH_TURN  = 16'h2000;
    localparam logic [YAW_W-1:0] QUARTER_TURN = 16'h4000;

    // 0.35355 in Q1.14 and the rounding offsets.
    localparam logic signed [MIXK_W-1:0] MIX_K = 15'sd5793;
    localparam logic signed [PROD_W:0] ROT_HALF = (PROD_W+1)'(64'd1 << (TRIG_BITS - 1));
    localparam logic signed [SUM_W-1:0] MIX_HALF = SUM_W'(64'd1 << (MIX_SHIFT - 1));
    localparam logic signed [RES_W-1:0] SAT_HI = RES_W'(32767);
    localparam logic signed [RES_W-1:0] SAT_LO = RES_W'(-32768);
    localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(16384);

    // Configuration reset values.
    localparam logic signed [GAIN_W-1:0] GAIN_RESET  = 16'sd4096;
    localparam logic [15:0]              LIMIT_RESET = 16'd300;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORWARD_GAIN  = 3'd0,
        CFG_LATERAL_GAIN  = 3'd1,
        CFG_SPIN_GAIN     = 3'd2,
        CFG_SPIN_ARM      = 3'd3,
        CFG_OFFLINE_LIMIT = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_BODY  = 2'd1,
        MODE_WORLD = 2'd2
    } t_mode;

    typedef struct packed {
        logic signed [GAIN_W-1:0] forward_gain;
        logic signed [GAIN_W-1:0] lateral_gain;
        logic signed [GAIN_W-1:0] spin_gain;
        logic signed [GAIN_W-1:0] spin_arm;
        logic [15:0]              offline_limit;
    } t_cfg;

    typedef struct packed {
        logic signed [STICK_W-1:0] stick_forward;
        logic signed [STICK_W-1:0] stick_lateral;
        logic signed [STICK_W-1:0] stick_spin;
        logic                      power_switch_up;
        logic                      frame_switch_down;
        logic [15:0]               link_silence;
        logic [YAW_W-1:0]          yaw_turn;
    } t_in_word;

    // After gain scaling and trig lookup.
    typedef struct packed {
        t_mode                    mode;
        logic signed [VEL_W-1:0]  vx;
        logic signed [VEL_W-1:0]  vy;
        logic signed [VEL_W-1:0]  vz;
        logic signed [TRIG_W-1:0] sn;
        logic signed [TRIG_W-1:0] cs;
    } t_scaled;

    // After rotation into the body frame.
    typedef struct packed {
        t_mode                    mode;
        logic signed [ROT_W-1:0]  nx;
        logic signed [ROT_W-1:0]  ny;
        logic signed [SPIN_W-1:0] spin;
    } t_rotated;

    typedef struct packed {
        t_mode                     mode;
        logic signed [WHEEL_W-1:0] wheel_left_front;
        logic signed [WHEEL_W-1:0] wheel_left_rear;
        logic signed [WHEEL_W-1:0] wheel_right_rear;
        logic signed [WHEEL_W-1:0] wheel_right_front;
    } t_out_word;

    // Quarter-wave sine table, Q1.14.
    localparam logic [14:0] SINE_Q [33] = '{
        15'd0,     15'd804,   15'd1606,  15'd2404,  15'd3196,  15'd3981,  15'd4756,
        15'd5520,  15'd6270,  15'd7005,  15'd7723,  15'd8423,  15'd9102,  15'd9760,
        15'd10394, 15'd11003, 15'd11585, 15'd12140, 15'd12665, 15'd13160, 15'd13623,
        15'd14053, 15'd14449, 15'd14811, 15'd15137, 15'd15426, 15'd15679, 15'd15893,
        15'd16069, 15'd16207, 15'd16305, 15'd16364, 15'd16384
    };

    // Sine of a 16-bit turn fraction with linear interpolation on 9 bits.
    function automatic logic signed [TRIG_W-1:0] sine16(input logic [YAW_W-1:0] a);
        logic [1:0]  quad;
        logic [14:0] p;
        logic [5:0]  idx;
        logic [8:0]  frac;
        logic [14:0] base;
        logic [14:0] step;
        logic [23:0] prod;
        logic [14:0] mag;
        quad = a[15:14];
        p = {1'b0, a[13:0]};
        if (quad[0]) begin
            p = 15'h4000 - p;
        end
        idx  = p[14:9];
        frac = p[8:0];
        if (idx[5]) begin
            mag = SINE_Q[32];
        end else begin
            base = SINE_Q[idx];
            step = SINE_Q[6'(idx + 6'd1)] - base;
            prod = 24'(step) * 24'(frac);
            mag  = base + 15'(prod >> 9);
        end
        if (quad[1]) begin
            return -$signed({1'b0, mag});
        end
        return $signed({1'b0, mag});
    endfunction

endpackage

@@ rtl/core/ocwm_in_if.sv @@
// Input channel carrying one stick and switch word per handshake.
interface ocwm_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [ocwm_pkg::STICK_W-1:0]   stick_forward;
    logic signed [ocwm_pkg::STICK_W-1:0]   stick_lateral;
    logic signed [ocwm_pkg::STICK_W-1:0]   stick_spin;
    logic                                  power_switch_up;
    logic                                  frame_switch_down;
    logic [15:0]                           link_silence;
    logic [ocwm_pkg::YAW_W-1:0]            yaw_turn;

    modport source (
        output valid, stick_forward, stick_lateral, stick_spin,
               power_switch_up, frame_switch_down, link_silence, yaw_turn,
        input  ready
    );
    modport sink (
        input  valid, stick_forward, stick_lateral, stick_spin,
               power_switch_up, frame_switch_down, link_silence, yaw_turn,
        output ready
    );
endinterface

@@ rtl/core/ocwm_out_if.sv @@
// Output channel carrying the drive mode and four wheel commands per handshake.
interface ocwm_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            drive_mode;
    logic signed [ocwm_pkg::WHEEL_W-1:0]   wheel_left_front;
    logic signed [ocwm_pkg::WHEEL_W-1:0]   wheel_left_rear;
    logic signed [ocwm_pkg::WHEEL_W-1:0]   wheel_right_rear;
    logic signed [ocwm_pkg::WHEEL_W-1:0]   wheel_right_front;

    modport source (
        output valid, drive_mode, wheel_left_front, wheel_left_rear,
               wheel_right_rear, wheel_right_front,
        input  ready
    );
    modport sink (
        input  valid, drive_mode, wheel_left_front, wheel_left_rear,
               wheel_right_rear, wheel_right_front,
        output ready
    );
endinterface

@@ rtl/core/omni_chassis_wheel_mixer_core.sv @@
// Top level of the omni chassis wheel mixer: configuration registers and the pipeline.
// A word accepted at the input passes in order through the scale, product, rotation,
// mix product and wheel sum registers before it is valid at the output.
// Throughput: one word per cycle while the output takes its words; each of the five
// stages holds one word and advances when empty or when the stage after it advances.
// Reset (synchronous, active low) empties every stage and returns the gains and
// spin arm to 1.0 in Q4.12 and the offline limit to 300.
module omni_chassis_wheel_mixer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ocwm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [15:0]                       i_cfg_wdata,
    ocwm_in_if.sink                           i_in,
    ocwm_out_if.source                        o_out
);

    ocwm_pkg::t_cfg       r_cfg;
    ocwm_pkg::t_cfg       n_cfg;
    ocwm_pkg::t_in_word   w_in_word;
    ocwm_pkg::t_scaled    w_scaled;
    ocwm_pkg::t_rotated   w_rotated;
    ocwm_pkg::t_out_word  w_out_word;
    logic                 w_scaled_valid;
    logic                 w_scaled_ready;
    logic                 w_rot_valid;
    logic                 w_rot_ready;

    // Configuration writes; an index past the last register is ignored.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                ocwm_pkg::CFG_FORWARD_GAIN:  n_cfg.forward_gain  = $signed(i_cfg_wdata);
                ocwm_pkg::CFG_LATERAL_GAIN:  n_cfg.lateral_gain  = $signed(i_cfg_wdata);
                ocwm_pkg::CFG_SPIN_GAIN:     n_cfg.spin_gain     = $signed(i_cfg_wdata);
                ocwm_pkg::CFG_SPIN_ARM:      n_cfg.spin_arm      = $signed(i_cfg_wdata);
                ocwm_pkg::CFG_OFFLINE_LIMIT: n_cfg.offline_limit = i_cfg_wdata;
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.forward_gain  <= ocwm_pkg::GAIN_RESET;
            r_cfg.lateral_gain  <= ocwm_pkg::GAIN_RESET;
            r_cfg.spin_gain     <= ocwm_pkg::GAIN_RESET;
            r_cfg.spin_arm      <= ocwm_pkg::GAIN_RESET;
            r_cfg.offline_limit <= ocwm_pkg::LIMIT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Gather the input word.
    assign w_in_word.stick_forward     = i_in.stick_forward;
    assign w_in_word.stick_lateral     = i_in.stick_lateral;
    assign w_in_word.stick_spin        = i_in.stick_spin;
    assign w_in_word.power_switch_up   = i_in.power_switch_up;
    assign w_in_word.frame_switch_down = i_in.frame_switch_down;
    assign w_in_word.link_silence      = i_in.link_silence;
    assign w_in_word.yaw_turn          = i_in.yaw_turn;

    ocwm_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in.valid),
        .i_word  (w_in_word),
        .o_ready (i_in.ready),
        .o_valid (w_scaled_valid),
        .o_data  (w_scaled),
        .i_ready (w_scaled_ready)
    );

    ocwm_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_scaled_valid),
        .i_data  (w_scaled),
        .o_ready (w_scaled_ready),
        .o_valid (w_rot_valid),
        .o_data  (w_rotated),
        .i_ready (w_rot_ready)
    );

    ocwm_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_rot_valid),
        .i_data  (w_rotated),
        .o_ready (w_rot_ready),
        .o_valid (o_out.valid),
        .o_data  (w_out_word),
        .i_ready (o_out.ready)
    );

    // Spread the result word onto the output channel.
    assign o_out.drive_mode        = 2'(w_out_word.mode);
    assign o_out.wheel_left_front  = w_out_word.wheel_left_front;
    assign o_out.wheel_left_rear   = w_out_word.wheel_left_rear;
    assign o_out.wheel_right_rear  = w_out_word.wheel_right_rear;
    assign o_out.wheel_right_front = w_out_word.wheel_right_front;

`ifndef SYNTHESIS
    // A no-drive word never carries a stale wheel command.
    a_no_drive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.drive_mode == ocwm_pkg::MODE_NONE) |->
        (o_out.wheel_left_front == '0 && o_out.wheel_left_rear == '0 &&
         o_out.wheel_right_rear == '0 && o_out.wheel_right_front == '0))
        else $error("no-drive word with nonzero wheel command");

    // With nothing waiting at the output, the whole pipeline can move.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input stalled while output is empty");

    // A write to the offline limit lands in its register.
    a_limit_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_idx == ocwm_pkg::CFG_OFFLINE_LIMIT) |=>
        (r_cfg.offline_limit == $past(i_cfg_wdata)))
        else $error("offline limit write lost");
`endif

endmodule

@@ rtl/core/ocwm_scale.sv @@
// First pipeline stage: drive mode, gain scaling and sine/cosine lookup.
module ocwm_scale (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ocwm_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    input  ocwm_pkg::t_in_word  i_word,
    output logic                o_ready,
    output logic                o_valid,
    output ocwm_pkg::t_scaled   o_data,
    input  logic                i_ready
);

    logic                        r_valid;
    ocwm_pkg::t_scaled           r_data;
    ocwm_pkg::t_scaled           n_data;
    logic                        w_en;
    logic [ocwm_pkg::YAW_W-1:0]  w_theta;

    // The stage moves when it is empty or its word is taken.
    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Heading plus one eighth turn, wrapping around the full turn.
    assign w_theta = (i_word.yaw_turn & ocwm_pkg::ANGLE_MASK) + ocwm_pkg::EIGHTH_TURN;

    // Mode selection and velocity scaling.
    always_comb begin
        if (i_word.link_silence > i_cfg.offline_limit || !i_word.power_switch_up) begin
            n_data.mode = ocwm_pkg::MODE_NONE;
        end else if (i_word.frame_switch_down) begin
            n_data.mode = ocwm_pkg::MODE_BODY;
        end else begin
            n_data.mode = ocwm_pkg::MODE_WORLD;
        end
        n_data.vx = ocwm_pkg::VEL_W'(i_word.stick_forward)
                  * ocwm_pkg::VEL_W'(i_cfg.forward_gain);
        n_data.vy = -(ocwm_pkg::VEL_W'(i_word.stick_lateral)
                  * ocwm_pkg::VEL_W'(i_cfg.lateral_gain));
        n_data.vz = -(ocwm_pkg::VEL_W'(i_word.stick_spin)
                  * ocwm_pkg::VEL_W'(i_cfg.spin_gain));
        // Body frame uses an identity rotation, which is exact after rounding.
        if (n_data.mode == ocwm_pkg::MODE_WORLD) begin
            n_data.sn = ocwm_pkg::sine16(w_theta);
            n_data.cs = ocwm_pkg::sine16(w_theta + ocwm_pkg::QUARTER_TURN);
        end else begin
            n_data.sn = '0;
            n_data.cs = ocwm_pkg::TRIG_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

@@ rtl/core/ocwm_rotate.sv @@
// Two pipeline stages: trig and spin products, then the rounded rotation.
module ocwm_rotate (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ocwm_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    input  ocwm_pkg::t_scaled   i_data,
    output logic                o_ready,
    output logic                o_valid,
    output ocwm_pkg::t_rotated  o_data,
    input  logic                i_ready
);

    localparam int PW = ocwm_pkg::PROD_W;

    // Product stage registers.
    logic                  r_prod_valid;
    ocwm_pkg::t_mode       r_prod_mode;
    logic signed [PW-1:0]  r_pxc;
    logic signed [PW-1:0]  r_pys;
    logic signed [PW-1:0]  r_pyc;
    logic signed [PW-1:0]  r_pxs;
    logic signed [PW-1:0]  r_pspin;

    // Rotation stage registers.
    logic                  r_rot_valid;
    ocwm_pkg::t_rotated    r_rot;
    ocwm_pkg::t_rotated    n_rot;

    logic                  w_prod_en;
    logic                  w_rot_en;
    logic signed [PW:0]    w_sum_x;
    logic signed [PW:0]    w_sum_y;

    // Each stage moves when it is empty or the next one moves.
    assign w_rot_en  = !r_rot_valid || i_ready;
    assign w_prod_en = !r_prod_valid || w_rot_en;
    assign o_ready   = w_prod_en;
    assign o_valid   = r_rot_valid;
    assign o_data    = r_rot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_rot_valid  <= 1'b0;
        end else begin
            if (w_prod_en) begin
                r_prod_valid <= i_valid;
            end
            if (w_rot_en) begin
                r_rot_valid <= r_prod_valid;
            end
        end
    end

    // Products of velocity with sine, cosine and the spin arm.
    always_ff @(posedge i_clk) begin
        if (w_prod_en && i_valid) begin
            r_prod_mode <= i_data.mode;
            r_pxc   <= PW'(i_data.vx) * PW'(i_data.cs);
            r_pys   <= PW'(i_data.vy) * PW'(i_data.sn);
            r_pyc   <= PW'(i_data.vy) * PW'(i_data.cs);
            r_pxs   <= PW'(i_data.vx) * PW'(i_data.sn);
            r_pspin <= PW'(i_cfg.spin_arm) * PW'(i_data.vz);
        end
    end

    // Rounded sums back to velocity scale; spin term aligned to the mix scale.
    assign w_sum_x = (PW+1)'(r_pxc) + (PW+1)'(r_pys) + ocwm_pkg::ROT_HALF;
    assign w_sum_y = (PW+1)'(r_pyc) - (PW+1)'(r_pxs) + ocwm_pkg::ROT_HALF;

    always_comb begin
        n_rot.mode = r_prod_mode;
        n_rot.nx   = ocwm_pkg::ROT_W'(w_sum_x >>> ocwm_pkg::TRIG_BITS);
        n_rot.ny   = ocwm_pkg::ROT_W'(w_sum_y >>> ocwm_pkg::TRIG_BITS);
        n_rot.spin = ocwm_pkg::SPIN_W'(r_pspin)
                   <<< (ocwm_pkg::TRIG_BITS - ocwm_pkg::FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (w_rot_en && r_prod_valid) begin
            r_rot <= n_rot;
        end
    end

endmodule

@@ rtl/core/ocwm_mix.sv @@
// Two pipeline stages: omni mix products, then wheel sums, rounding and clamping.
module ocwm_mix (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  ocwm_pkg::t_rotated   i_data,
    output logic                 o_ready,
    output logic                 o_valid,
    output ocwm_pkg::t_out_word  o_data,
    input  logic                 i_ready
);

    localparam int KW = ocwm_pkg::KPROD_W;
    localparam int SW = ocwm_pkg::SUM_W;
    localparam int RW = ocwm_pkg::RES_W;

    // Mix product stage registers.
    logic                               r_kp_valid;
    ocwm_pkg::t_mode                    r_kp_mode;
    logic signed [KW-1:0]               r_ka;
    logic signed [KW-1:0]               r_kb;
    logic signed [ocwm_pkg::SPIN_W-1:0] r_spin;

    // Output register.
    logic                  r_out_valid;
    ocwm_pkg::t_out_word   r_out;
    ocwm_pkg::t_out_word   n_out;

    logic                                w_kp_en;
    logic                                w_out_en;
    logic signed [ocwm_pkg::DIFF_W-1:0]  w_diff;
    logic signed [ocwm_pkg::DIFF_W-1:0]  w_plus;
    logic signed [SW-1:0]                w_ka;
    logic signed [SW-1:0]                w_kb;
    logic signed [SW-1:0]                w_s;
    logic signed [SW-1:0]                w_tot [4];
    logic signed [ocwm_pkg::WHEEL_W-1:0] w_wheel [4];

    assign w_out_en = !r_out_valid || i_ready;
    assign w_kp_en  = !r_kp_valid || w_out_en;
    assign o_ready  = w_kp_en;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_kp_en) begin
                r_kp_valid <= i_valid;
            end
            if (w_out_en) begin
                r_out_valid <= r_kp_valid;
            end
        end
    end

    // Difference and sum of the velocities times the 0.35355 mix constant.
    assign w_diff = ocwm_pkg::DIFF_W'(i_data.nx) - ocwm_pkg::DIFF_W'(i_data.ny);
    assign w_plus = ocwm_pkg::DIFF_W'(i_data.nx) + ocwm_pkg::DIFF_W'(i_data.ny);

    always_ff @(posedge i_clk) begin
        if (w_kp_en && i_valid) begin
            r_kp_mode <= i_data.mode;
            r_ka      <= KW'(w_diff) * KW'(ocwm_pkg::MIX_K);
            r_kb      <= KW'(w_plus) * KW'(ocwm_pkg::MIX_K);
            r_spin    <= i_data.spin;
        end
    end

    // Wheel sums with the rounding offset folded in.
    assign w_ka = SW'(r_ka);
    assign w_kb = SW'(r_kb);
    assign w_s  = SW'(r_spin);
    assign w_tot[0] = w_ka - w_s + ocwm_pkg::MIX_HALF;
    assign w_tot[1] = w_kb - w_s + ocwm_pkg::MIX_HALF;
    assign w_tot[2] = ocwm_pkg::MIX_HALF - w_ka - w_s;
    assign w_tot[3] = ocwm_pkg::MIX_HALF - w_kb - w_s;

    // Scale down and clamp each wheel to the 16-bit range.
    always_comb begin
        logic signed [RW-1:0] res;
        for (int k = 0; k < 4; k++) begin
            res = RW'(w_tot[k] >>> ocwm_pkg::MIX_SHIFT);
            if (res > ocwm_pkg::SAT_HI) begin
                res = ocwm_pkg::SAT_HI;
            end else if (res < ocwm_pkg::SAT_LO) begin
                res = ocwm_pkg::SAT_LO;
            end
            w_wheel[k] = ocwm_pkg::WHEEL_W'(res);
        end
    end

    // No-drive mode sends zero commands.
    always_comb begin
        n_out.mode = r_kp_mode;
        if (r_kp_mode == ocwm_pkg::MODE_NONE) begin
            n_out.wheel_left_front  = '0;
            n_out.wheel_left_rear   = '0;
            n_out.wheel_right_rear  = '0;
            n_out.wheel_right_front = '0;
        end else begin
            n_out.wheel_left_front  = w_wheel[0];
            n_out.wheel_left_rear   = w_wheel[1];
            n_out.wheel_right_rear  = w_wheel[2];
            n_out.wheel_right_front = w_wheel[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_en && r_kp_valid) begin
            r_out <= n_out;
        end
    end

endmodule

@@ verif/omni_chassis_wheel_mixer_core_tb.sv @@
// Self-checking testbench for the omni chassis wheel mixer core.
module omni_chassis_wheel_mixer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ocwm_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;
    localparam int NUM_REGS     = 5;
    localparam int DRAIN_CYCLES = 10;
    localparam int WHEEL_SHIFT  = 26;
    localparam int ROT_SHIFT    = 14;
    localparam longint MIX_GAIN = 5793;
    localparam logic [15:0] HEADING_MASK = 16'hFFFF << (16 - ANGLE_BITS);
    localparam logic [15:0] HEADING_OFFSET = 16'h2000;
    localparam logic [15:0] COSINE_OFFSET  = 16'h4000;
    localparam logic signed [10:0] STICK_MIN = 11'b100_0000_0000;
    localparam logic signed [10:0] STICK_MAX = 11'b011_1111_1111;
    localparam int SINE_TABLE [33] = '{
        0, 804, 1606, 2404, 3196, 3981, 4756, 5520,
        6270, 7005, 7723, 8423, 9102, 9760, 10394, 11003,
        11585, 12140, 12665, 13160, 13623, 14053, 14449, 14811,
        15137, 15426, 15679, 15893, 16069, 16207, 16305, 16364,
        16384
    };

    // Mirrors the registers and holds the wheel words still to come.
    class mixer_scoreboard;
        logic signed [15:0] forward_gain;
        logic signed [15:0] lateral_gain;
        logic signed [15:0] spin_gain;
        logic signed [15:0] spin_arm;
        logic [15:0]        offline_limit;
        t_out_word          expected_wheels[$];
        int                 mismatches;

        function new();
            forward_gain  = GAIN_RESET;
            lateral_gain  = GAIN_RESET;
            spin_gain     = GAIN_RESET;
            spin_arm      = GAIN_RESET;
            offline_limit = LIMIT_RESET;
            mismatches    = 0;
        endfunction

        // Indexes past the last register are ignored by the block.
        function void set_reg(logic [2:0] idx, logic [15:0] value);
            case (idx)
                CFG_FORWARD_GAIN:  forward_gain  = value;
                CFG_LATERAL_GAIN:  lateral_gain  = value;
                CFG_SPIN_GAIN:     spin_gain     = value;
                CFG_SPIN_ARM:      spin_arm      = value;
                CFG_OFFLINE_LIMIT: offline_limit = value;
                default: ;
            endcase
        endfunction

        // Q1.14 sine of a turn fraction from the interpolated quarter wave.
        function longint sine_q14(logic [15:0] turn);
            int unsigned pos;
            int unsigned idx;
            int unsigned frac;
            longint      mag;
            pos = turn[13:0];
            if (turn[14]) begin
                pos = 16384 - pos;
            end
            idx  = pos >> 9;
            frac = pos & 511;
            if (idx >= 32) begin
                mag = SINE_TABLE[32];
            end else begin
                mag = SINE_TABLE[idx]
                    + (((SINE_TABLE[idx+1] - SINE_TABLE[idx]) * longint'(frac)) >>> 9);
            end
            return turn[15] ? -mag : mag;
        endfunction

        // Round to nearest with ties toward plus infinity.
        function longint round_off(longint v, int shift);
            return (v + (longint'(1) <<< (shift - 1))) >>> shift;
        endfunction

        function logic signed [15:0] clamp_wheel(longint v);
            if (v > 32767) begin
                return 16'sh7FFF;
            end
            if (v < -32768) begin
                return 16'sh8000;
            end
            return 16'(v);
        endfunction

        // Works out the wheel word that an accepted stick word must produce.
        function void note_stick_word(t_in_word w);
            t_out_word   wheels;
            longint      vx;
            longint      vy;
            longint      vz;
            longint      sn;
            longint      cs;
            longint      nx;
            longint      ny;
            longint      diff_mix;
            longint      sum_mix;
            longint      spin_term;
            logic [15:0] heading;
            wheels = '0;
            if (w.link_silence > offline_limit || !w.power_switch_up) begin
                wheels.mode = MODE_NONE;
            end else if (w.frame_switch_down) begin
                wheels.mode = MODE_BODY;
            end else begin
                wheels.mode = MODE_WORLD;
            end
            if (wheels.mode != MODE_NONE) begin
                vx = longint'(w.stick_forward) * longint'(forward_gain);
                vy = -(longint'(w.stick_lateral) * longint'(lateral_gain));
                vz = -(longint'(w.stick_spin) * longint'(spin_gain));
                // World frame: rotate the translation by heading plus an eighth turn.
                if (wheels.mode == MODE_WORLD) begin
                    heading = (w.yaw_turn & HEADING_MASK) + HEADING_OFFSET;
                    sn = sine_q14(heading);
                    cs = sine_q14(heading + COSINE_OFFSET);
                    nx = round_off(vx * cs + vy * sn, ROT_SHIFT);
                    ny = round_off(vy * cs - vx * sn, ROT_SHIFT);
                    vx = nx;
                    vy = ny;
                end
                diff_mix  = MIX_GAIN * (vx - vy);
                sum_mix   = MIX_GAIN * (vx + vy);
                spin_term = longint'(spin_arm) * vz * 4;
                wheels.wheel_left_front  = clamp_wheel(round_off(diff_mix - spin_term,
                                                                 WHEEL_SHIFT));
                wheels.wheel_left_rear   = clamp_wheel(round_off(sum_mix - spin_term,
                                                                 WHEEL_SHIFT));
                wheels.wheel_right_rear  = clamp_wheel(round_off(-(diff_mix + spin_term),
                                                                 WHEEL_SHIFT));
                wheels.wheel_right_front = clamp_wheel(round_off(-(sum_mix + spin_term),
                                                                 WHEEL_SHIFT));
            end
            expected_wheels.push_back(wheels);
        endfunction

        // Compares a wheel word from the block with the oldest expected one.
        function void check_wheel_word(t_out_word got);
            t_out_word want;
            if (expected_wheels.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected wheel word: mode %0d lf %0d lr %0d rr %0d rf %0d",
                             got.mode, got.wheel_left_front, got.wheel_left_rear,
                             got.wheel_right_rear, got.wheel_right_front);
                end
                return;
            end
            want = expected_wheels.pop_front();
            if (got.mode !== want.mode
                    || got.wheel_left_front !== want.wheel_left_front
                    || got.wheel_left_rear !== want.wheel_left_rear
                    || got.wheel_right_rear !== want.wheel_right_rear
                    || got.wheel_right_front !== want.wheel_right_front) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("wheel mismatch: expected mode %0d lf %0d lr %0d rr %0d rf %0d",
                             want.mode, want.wheel_left_front, want.wheel_left_rear,
                             want.wheel_right_rear, want.wheel_right_front);
                    $display("                got      mode %0d lf %0d lr %0d rr %0d rf %0d",
                             got.mode, got.wheel_left_front, got.wheel_left_rear,
                             got.wheel_right_rear, got.wheel_right_front);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_wdata;

    ocwm_in_if  in_if ();
    ocwm_out_if out_if ();

    omni_chassis_wheel_mixer_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    mixer_scoreboard sb;
    int              cycle_count = 0;
    int              idle_odds   = 4;
    bit              calm        = 1'b0;
    int              stall_left  = 0;
    t_in_word        seen_in;
    t_out_word       seen_out;

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit in case the pipeline hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[omni_chassis_wheel_mixer_core] ERROR");
            $finish;
        end
    end

    // Output side: random stall bursts unless calm.
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (!calm && $urandom_range(1, idle_odds) == 1) begin
                stall_left = $urandom_range(0, 7);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Watch both handshakes and feed the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                seen_in.stick_forward     = in_if.stick_forward;
                seen_in.stick_lateral     = in_if.stick_lateral;
                seen_in.stick_spin        = in_if.stick_spin;
                seen_in.power_switch_up   = in_if.power_switch_up;
                seen_in.frame_switch_down = in_if.frame_switch_down;
                seen_in.link_silence      = in_if.link_silence;
                seen_in.yaw_turn          = in_if.yaw_turn;
                sb.note_stick_word(seen_in);
            end
            if (out_if.valid && out_if.ready) begin
                seen_out.mode              = t_mode'(out_if.drive_mode);
                seen_out.wheel_left_front  = out_if.wheel_left_front;
                seen_out.wheel_left_rear   = out_if.wheel_left_rear;
                seen_out.wheel_right_rear  = out_if.wheel_right_rear;
                seen_out.wheel_right_front = out_if.wheel_right_front;
                sb.check_wheel_word(seen_out);
            end
        end
    end

    function automatic t_in_word make_word(int sf, int sl, int ss, bit power, bit body,
                                           int silence, int yaw);
        t_in_word w;
        w.stick_forward     = 11'(sf);
        w.stick_lateral     = 11'(sl);
        w.stick_spin        = 11'(ss);
        w.power_switch_up   = power;
        w.frame_switch_down = body;
        w.link_silence      = 16'(silence);
        w.yaw_turn          = 16'(yaw);
        return w;
    endfunction

    function automatic logic signed [10:0] random_stick();
        case ($urandom_range(0, 7))
            0:       return STICK_MIN;
            1:       return STICK_MAX;
            2:       return 11'(int'($urandom_range(0, 16)) - 8);
            default: return 11'($urandom);
        endcase
    endfunction

    // Mostly driving words with silence at or under the limit, some cut by power or link.
    function automatic t_in_word random_stick_word(logic [15:0] limit);
        t_in_word w;
        w.stick_forward     = random_stick();
        w.stick_lateral     = random_stick();
        w.stick_spin        = random_stick();
        w.power_switch_up   = ($urandom_range(0, 7) != 0);
        w.frame_switch_down = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0, 1, 2, 3: w.link_silence = 16'($urandom_range(0, limit));
            4:          w.link_silence = limit;
            5:          w.link_silence = limit + 16'd1;
            6:          w.link_silence = 16'hFFFF;
            default:    w.link_silence = 16'($urandom);
        endcase
        w.yaw_turn = 16'($urandom);
        return w;
    endfunction

    // Offers one word and holds it until accepted, then maybe idles a while.
    task automatic send_word(input t_in_word w);
        in_if.valid             <= 1'b1;
        in_if.stick_forward     <= w.stick_forward;
        in_if.stick_lateral     <= w.stick_lateral;
        in_if.stick_spin        <= w.stick_spin;
        in_if.power_switch_up   <= w.power_switch_up;
        in_if.frame_switch_down <= w.frame_switch_down;
        in_if.link_silence      <= w.link_silence;
        in_if.yaw_turn          <= w.yaw_turn;
        do @(posedge i_clk); while (!in_if.ready);
        if (!calm && $urandom_range(1, idle_odds) == 1) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // Writes all five registers, then one index past the end that must be ignored.
    task automatic program_regs(input logic [15:0] fwd, lat, spin, arm, limit);
        logic [15:0] vals [NUM_REGS];
        logic [2:0]  idx;
        logic [15:0] data;
        vals = '{fwd, lat, spin, arm, limit};
        for (int i = 0; i <= NUM_REGS; i++) begin
            if (i < NUM_REGS) begin
                idx  = 3'(i);
                data = vals[i];
            end else begin
                idx  = 3'($urandom_range(NUM_REGS, 7));
                data = 16'($urandom);
            end
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= idx;
            i_cfg_wdata <= data;
            sb.set_reg(idx, data);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Stops offering words and waits for the pipeline to empty.
    task automatic drain_pipeline();
        in_if.valid <= 1'b0;
        while (sb.expected_wheels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++) begin
            send_word(random_stick_word(sb.offline_limit));
        end
    endtask

    // Main sequence.
    initial begin
        sb = new();
        i_rst_n                 <= 1'b0;
        i_cfg_we                <= 1'b0;
        i_cfg_idx               <= CFG_FORWARD_GAIN;
        i_cfg_wdata             <= '0;
        in_if.valid             <= 1'b0;
        in_if.stick_forward     <= '0;
        in_if.stick_lateral     <= '0;
        in_if.stick_spin        <= '0;
        in_if.power_switch_up   <= 1'b0;
        in_if.frame_switch_down <= 1'b0;
        in_if.link_silence      <= '0;
        in_if.yaw_turn          <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words under the reset gains: stick extremes, both frames,
        // heading quadrant edges and wrap, the power cut and the silence limit.
        send_word(make_word(0, 0, 0, 1, 1, 0, 0));
        send_word(make_word(1023, 1023, 1023, 1, 1, 0, 0));
        send_word(make_word(-1024, -1024, -1024, 1, 1, 0, 0));
        send_word(make_word(1, 0, 0, 1, 1, 0, 0));
        send_word(make_word(1023, -1024, 1023, 1, 0, 0, 'h0000));
        send_word(make_word(-1024, 1023, -1024, 1, 0, 0, 'h2000));
        send_word(make_word(1023, 1023, 0, 1, 0, 0, 'h6000));
        send_word(make_word(500, -300, 200, 1, 0, 0, 'hE000));
        send_word(make_word(777, -333, 11, 1, 0, 0, 'hFFFF));
        send_word(make_word(-1, 1, -1, 1, 0, 0, 'h1FFF));
        send_word(make_word(1, 1, 1, 1, 0, 0, 'h5FFF));
        send_word(make_word(1, -1, 1, 1, 0, 0, 'hA000));
        send_word(make_word(-1024, -1024, 1023, 1, 0, 0, 'h3FFF));
        send_word(make_word(1023, 1023, 1023, 0, 1, 0, 0));
        send_word(make_word(1023, 1023, 1023, 0, 0, 0, 'h1234));
        send_word(make_word(600, 600, 600, 1, 1, 300, 0));
        send_word(make_word(600, 600, 600, 1, 0, 301, 'h4000));
        send_word(make_word(600, 600, 600, 0, 0, 'hFFFF, 'h8000));
        drain_pipeline();

        // Largest gains and arm: the spin term drives the wheels into saturation.
        program_regs(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        send_word(make_word(1023, 1023, 1023, 1, 1, 'hFFFF, 0));
        send_word(make_word(-1024, -1024, -1024, 1, 0, 'hFFFF, 'h2000));
        send_word(make_word(1023, -1024, -1024, 1, 0, 'hFFFE, 'hC000));
        send_random(250);
        drain_pipeline();

        // Most negative gains and a zero silence limit.
        idle_odds = 3;
        program_regs(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000);
        send_random(250);
        drain_pipeline();

        // Zero gains: every driving word must give zero wheels.
        idle_odds = 16;
        program_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'($urandom));
        send_random(200);
        drain_pipeline();

        // Random settings; the last phase runs without any idling.
        for (int phase = 0; phase < 4; phase++) begin
            idle_odds = $urandom_range(2, 8);
            calm      = (phase == 3);
            program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom));
            send_random(250);
            drain_pipeline();
        end

        if (sb.mismatches == 0 && sb.expected_wheels.size() == 0) begin
            $display("[omni_chassis_wheel_mixer_core] OK");
        end else begin
            $display("[omni_chassis_wheel_mixer_core] ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/ocwm_pkg.sv
rtl/core/ocwm_in_if.sv
rtl/core/ocwm_out_if.sv
rtl/core/ocwm_scale.sv
rtl/core/ocwm_rotate.sv
rtl/core/ocwm_mix.sv
rtl/core/omni_chassis_wheel_mixer_core.sv
verif/omni_chassis_wheel_mixer_core_tb.sv
